// ===== src/sawsyn_pkg.sv =====
// sawsyn_pkg: shared constants, register codes, sequencer states and the
// sine table entry function for the additive sawtooth synthesizer
// no dependencies
package sawsyn_pkg;

  // default sizes handed to the top level
  localparam int unsigned MAX_HARMONICS_DEF   = 64;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned SAMPLE_BITS_DEF     = 16;

  // magnitude width of a table entry (q1.15, never negative)
  localparam int unsigned SINE_W  = 15;
  // reciprocal weight width (q0.16, 17 bits for the first harmonic)
  localparam int unsigned RECIP_W = 17;

  // configuration register indexes
  localparam logic [1:0] CFG_PHASE_STEP     = 2'd0;
  localparam logic [1:0] CFG_HARMONIC_COUNT = 2'd1;
  localparam logic [1:0] CFG_GAIN           = 2'd2;

  // register reset values
  localparam logic [31:0] PHASE_STEP_RST     = 32'd39370534;
  localparam logic [6:0]  HARMONIC_COUNT_RST = 7'd16;
  localparam logic [15:0] GAIN_RST           = 16'd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_GAIN_LO,
    ST_GAIN_HI,
    ST_SUM,
    ST_ROUND
  } state_t;

  // sin(pi/2 * k / 2^bits) in q1.15 by an integer taylor series on a q30 angle
  function automatic logic [SINE_W-1:0] sine_entry(int unsigned k, int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned prod;
    longint unsigned val;
    x    = (64'd1686629713 * longint'(k)) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int i = 1; i <= 12; i++) begin
      prod = (term * x2) >> 30;
      case (i)
        1:       term = prod / 6;
        2:       term = prod / 20;
        3:       term = prod / 42;
        4:       term = prod / 72;
        5:       term = prod / 110;
        6:       term = prod / 156;
        7:       term = prod / 210;
        8:       term = prod / 272;
        9:       term = prod / 342;
        10:      term = prod / 420;
        11:      term = prod / 506;
        default: term = prod / 600;
      endcase
      if (i % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    val = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (val > 64'd32767) begin
      val = 64'd32767;
    end
    return val[SINE_W-1:0];
  endfunction

endpackage

// ===== src/sawsyn_sine_rom.sv =====
// sawsyn_sine_rom: quarter-wave sine table with registered read
// depends on sawsyn_pkg (sine_entry, SINE_W)
module sawsyn_sine_rom import sawsyn_pkg::*; #(
  parameter int unsigned TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic [TABLE_BITS:0]   addr,
  output logic [SINE_W-1:0]     data
);

  localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

  logic [SINE_W-1:0] rom [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    localparam logic [SINE_W-1:0] ENTRY = sine_entry(k, TABLE_BITS);
    assign rom[k] = ENTRY;
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule

// ===== src/additive_sawtooth_synth_unit.sv =====
// additive_sawtooth_synth_unit: band-limited sawtooth by additive synthesis
// depends on sawsyn_pkg and sawsyn_sine_rom

// Each input beat yields one output sample: the sum of sin(n*phase)/n over
// harmonics 1..harmonic_count (held to MAX_HARMONICS), scaled by the q2.14
// gain, rounded half up and saturated to SAMPLE_BITS signed, with a clip flag.
// Restart in the input beat zeroes the phase first; after each sample the
// 32-bit phase advances by phase_step. One shared harmonic pipeline (sine
// table read, weight multiply, accumulate) takes one harmonic per cycle;
// once the last harmonic has drained through the table, multiplier and
// accumulate stages, the gain multiply runs in two halves, the halves are
// merged and the sum is rounded into the output register. The input is
// ready only while the sequencer idles, in the state after each rounding
// step, so a beat is taken only once the last one has left its rounding
// step. The result sits in an output register, so a new input beat is taken
// while the last sample still waits; the sequencer holds in its rounding step
// only if that sample has not been taken yet. Configuration writes are
// always ready and must be made while no beat is in work.
module additive_sawtooth_synth_unit import sawsyn_pkg::*; #(
  parameter int unsigned MAX_HARMONICS   = MAX_HARMONICS_DEF,
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [0] restart, [7:1] zero
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // [15:0] sample
  output logic [0:0]  m_tuser,    // [0] clipped
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // harmonic counter, holds 0..MAX_HARMONICS
  localparam int unsigned NW      = $clog2(MAX_HARMONICS + 1);
  // weight table index
  localparam int unsigned RW      = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int unsigned TB      = SINE_TABLE_BITS;
  // signed sine times weight
  localparam int unsigned PROD_W  = SINE_W + 1 + RECIP_W + 1;
  localparam int unsigned ACC_W   = PROD_W + NW;
  // gain multiply split into two halves of the accumulator
  localparam int unsigned LO_W    = ACC_W / 2;
  localparam int unsigned HI_W    = ACC_W - LO_W;
  localparam int unsigned V_W     = ACC_W + 17;
  localparam int unsigned SH      = 46 - SAMPLE_BITS;
  localparam int unsigned Q_W     = V_W - SH;

  localparam logic [TB:0]            ROM_TOP = (TB + 1)'(1 << TB);
  localparam logic signed [V_W-1:0]  HALF    = V_W'(1) << (SH - 1);
  localparam logic signed [Q_W-1:0]  Q_HI    = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Q_W-1:0]  Q_LO    = ~Q_HI;

  // configuration registers
  logic [31:0] phase_step;
  logic [6:0]  harmonic_count;
  logic [15:0] gain;

  // sequencer and datapath registers
  state_t state, state_next;
  logic [31:0]                 phase;
  logic [31:0]                 hp;
  logic [NW-1:0]               nidx;
  logic [NW-1:0]               count;
  logic                        v1, v2;
  logic                        neg1;
  logic [RECIP_W-1:0]          recip_q;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc;
  logic [LO_W+15:0]            plo;
  logic signed [HI_W+16:0]     phi;
  logic signed [V_W-1:0]       v;

  // control decoded from the state
  logic in_beat, issue, run_done, out_load;

  // weight table 1/n, round(65536/n) in q0.16
  logic [RECIP_W-1:0] recip_tab [1 << RW];

  for (genvar k = 0; k < (1 << RW); k++) begin : g_recip
    localparam int unsigned R = (k < MAX_HARMONICS) ? (65536 + (k + 1) / 2) / (k + 1) : 0;
    assign recip_tab[k] = RECIP_W'(R);
  end

  // quadrant fold: odd quadrants read the table backward, upper half negates
  logic [TB-1:0]     qidx;
  logic [TB:0]       rom_addr;
  logic [SINE_W-1:0] rom_data;

  assign qidx     = hp[29 -: TB];
  assign rom_addr = hp[30] ? (ROM_TOP - {1'b0, qidx}) : {1'b0, qidx};

  sawsyn_sine_rom #(
    .TABLE_BITS (TB)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  logic signed [SINE_W:0] sine_s;
  assign sine_s = neg1 ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

  // rounding and saturation of the scaled sum
  logic signed [V_W-1:0] t_round;
  logic signed [Q_W-1:0] q_full, q_sat;
  logic                  clip;

  always_comb begin
    t_round = v + HALF;
    q_full  = Q_W'(t_round >>> SH);
    clip    = 1'b0;
    q_sat   = q_full;
    if (q_full > Q_HI) begin
      q_sat = Q_HI;
      clip  = 1'b1;
    end else if (q_full < Q_LO) begin
      q_sat = Q_LO;
      clip  = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_RUN;
      ST_RUN:     if (run_done) state_next = ST_GAIN_LO;
      ST_GAIN_LO: state_next = ST_GAIN_HI;
      ST_GAIN_HI: state_next = ST_SUM;
      ST_SUM:     state_next = ST_ROUND;
      ST_ROUND:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // state decoded controls
  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    run_done = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_RUN: begin
        issue    = (nidx < count);
        run_done = (nidx >= count) && !v1 && !v2;
      end
      ST_ROUND: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign in_beat   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step     <= PHASE_STEP_RST;
      harmonic_count <= HARMONIC_COUNT_RST;
      gain           <= GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PHASE_STEP:     phase_step     <= cfg_data;
        CFG_HARMONIC_COUNT: harmonic_count <= cfg_data[6:0];
        CFG_GAIN:           gain           <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // phase accumulator: restart on the input beat, advance once the sample is loaded into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (in_beat) begin
      phase <= s_tdata[0] ? 32'd0 : phase;
    end else if (out_load) begin
      phase <= phase + phase_step;
    end
  end

  // harmonic pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  // harmonic issue: n*phase is built by repeated addition of the phase
  always_ff @(posedge clk) begin
    if (in_beat) begin
      hp   <= s_tdata[0] ? 32'd0 : phase;
      nidx <= '0;
      if (32'(harmonic_count) > MAX_HARMONICS) begin
        count <= NW'(MAX_HARMONICS);
      end else begin
        count <= NW'(harmonic_count);
      end
    end else if (issue) begin
      hp   <= hp + phase;
      nidx <= nidx + 1'b1;
    end
  end

  // table read stage, weight multiply stage, accumulate stage
  always_ff @(posedge clk) begin
    neg1    <= hp[31];
    recip_q <= recip_tab[nidx[RW-1:0]];
    prod    <= sine_s * $signed({1'b0, recip_q});
    if (in_beat) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // gain multiply in two halves, then merged
  always_ff @(posedge clk) begin
    if (state == ST_GAIN_LO) begin
      plo <= acc[LO_W-1:0] * gain;
    end
    if (state == ST_GAIN_HI) begin
      phi <= $signed(acc[ACC_W-1:LO_W]) * $signed({1'b0, gain});
    end
    if (state == ST_SUM) begin
      v <= (V_W'(phi) <<< LO_W) + $signed(V_W'(plo));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata    <= 16'(q_sat);
      m_tuser[0] <= clip;
    end
  end

endmodule

// ===== tb/sv/additive_sawtooth_synth_unit_test.sv =====
// testbench for additive_sawtooth_synth_unit: random stream traffic and register
// settings, every sample checked against an in-house sawtooth predictor
// depends on sawsyn_pkg and the synthesizer rtl
`timescale 1ns / 100ps

module additive_sawtooth_synth_unit_test;
  import sawsyn_pkg::*;

  localparam int unsigned TABLE_BITS  = SINE_TABLE_BITS_DEF;
  localparam int unsigned QTR         = 1 << TABLE_BITS;
  localparam longint      SAMPLE_MAX  = 32767;
  localparam longint      SAMPLE_MIN  = -32768;
  localparam int          STALL_LIMIT = 5000;
  localparam int          SETTLE      = 100;

  typedef struct {
    logic [15:0] value;
    logic        clipped;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_PHASE_STEP;
  logic [31:0] cfg_data = 32'd0;

  // predictor state: register copies and the phase accumulator
  logic [31:0] cur_step  = PHASE_STEP_RST;
  logic [6:0]  cur_count = HARMONIC_COUNT_RST;
  logic [15:0] cur_gain  = GAIN_RST;
  logic [31:0] saw_phase = 32'd0;
  int          quarter_sine [0:QTR];

  bit      restart_q [$];   // restart flags waiting to be sent
  sample_t sample_q [$];    // predicted samples, oldest first

  bit beat_sent = 1'b0;
  bit gaps_on   = 1'b1;
  int beats_queued  = 0;
  int beats_taken   = 0;
  int restarts      = 0;
  int samples_seen  = 0;
  int clipped_seen  = 0;
  int reg_writes    = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  additive_sawtooth_synth_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),     // [0] restart, [7:1] zero
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),     // [15:0] sample
    .m_tuser   (m_tuser),     // [0] clipped
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // quarter-wave entry: taylor series on a q30 angle, truncated terms,
  // scaled to q1.15 and rounded half up, capped at full scale
  function automatic int quarter_entry(input int unsigned k);
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned div;
    longint unsigned val;
    int unsigned     i;
    ang  = (64'd1686629713 * k) >> TABLE_BITS;
    ang2 = (ang * ang) >> 30;
    term = ang;
    sum  = ang;
    for (i = 1; i <= 12; i++) begin
      div  = (2 * i) * (2 * i + 1);
      term = ((term * ang2) >> 30) / div;
      if (i[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    val = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (val > 64'd32767) begin
      val = 64'd32767;
    end
    return int'(val);
  endfunction

  // full-wave sine from the quarter table: top two bits pick the quadrant,
  // odd quadrants read mirrored, the upper half-cycle is negated
  function automatic int harmonic_sine(input logic [31:0] ph);
    logic [1:0]  quad;
    int unsigned idx;
    int          s;
    quad = ph[31:30];
    idx  = (ph >> (30 - TABLE_BITS)) & (QTR - 1);
    s    = quad[0] ? quarter_sine[QTR - idx] : quarter_sine[idx];
    return quad[1] ? -s : s;
  endfunction

  // one sawtooth sample from the current settings, then the phase steps on
  function automatic sample_t synth_sample(input logic restart);
    longint      acc;
    longint      scaled;
    longint      rounded;
    int unsigned n;
    int unsigned k;
    int unsigned weight;
    logic [31:0] hp;
    sample_t     res;
    if (restart) begin
      saw_phase = 32'd0;
    end
    k   = (cur_count > MAX_HARMONICS_DEF) ? MAX_HARMONICS_DEF : cur_count;
    acc = 0;
    for (n = 1; n <= k; n++) begin
      hp     = n * saw_phase;
      weight = (65536 + n / 2) / n;
      acc    = acc + longint'(harmonic_sine(hp)) * longint'(weight);
    end
    // q31 sum times q2.14 gain is q45; keep 16 signed bits, ties go up
    scaled  = acc * longint'(cur_gain);
    rounded = (scaled + (longint'(1) << 29)) >>> 30;
    res.clipped = 1'b0;
    if (rounded > SAMPLE_MAX) begin
      res.value   = 16'h7FFF;
      res.clipped = 1'b1;
    end else if (rounded < SAMPLE_MIN) begin
      res.value   = 16'h8000;
      res.clipped = 1'b1;
    end else begin
      res.value = 16'(rounded);
    end
    saw_phase = saw_phase + cur_step;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: sample %0d, %s: expected %0d, got %0d",
               $time, samples_seen, what, want, got);
    end
  endtask

  // one register write; waits for a fresh falling edge so valid never drops and
  // rises within the same step between back-to-back writes
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PHASE_STEP:     cur_step  = value;
      CFG_HARMONIC_COUNT: cur_count = value[6:0];
      CFG_GAIN:           cur_gain  = value[15:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [31:0] step, input logic [6:0] count,
                               input logic [15:0] g);
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_HARMONIC_COUNT, {25'd0, count});
    write_reg(CFG_GAIN, {16'd0, g});
  endtask

  task automatic queue_beat(input bit restart);
    restart_q.push_back(restart);
    beats_queued++;
  endtask

  // block is idle once every beat went in and every sample came out
  task automatic drain;
    while (beats_taken != beats_queued || sample_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // random register setting, weighted toward musical values but with
  // the edges of each field mixed in
  task automatic random_setting;
    logic [31:0] step;
    logic [6:0]  count;
    logic [15:0] g;
    case ($urandom_range(5))
      0:       step = $urandom;
      1:       step = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
      2:       step = 32'h8000_0000;
      default: step = $urandom_range(200000000, 200000);
    endcase
    case ($urandom_range(9))
      0:       count = 7'd0;
      1:       count = 7'd64;
      2:       count = 7'($urandom_range(127, 65));
      default: count = 7'($urandom_range(64, 1));
    endcase
    case ($urandom_range(5))
      0:       g = 16'd0;
      1:       g = 16'hFFFF;
      default: g = 16'($urandom_range(65535));
    endcase
    apply_setting(step, count, g);
  endtask

  // input side: hold a beat until taken, otherwise offer the next one
  // unless this cycle is a random gap
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || beat_sent) begin
      if (restart_q.size() != 0 && !(gaps_on && $urandom_range(99) < 6)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart_q.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    beat_sent = 1'b0;
  end

  // accepted input beat: predict its sample right away
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      sample_q.push_back(synth_sample(s_tdata[0]));
      beats_taken++;
      if (s_tdata[0]) begin
        restarts++;
      end
      beat_sent = 1'b1;
    end
  end

  // output side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(gaps_on && $urandom_range(99) < 6);
    end
  end

  // compare each delivered sample with the oldest prediction
  always @(posedge clk) begin
    sample_t want;
    if (!rst && m_tvalid && m_tready) begin
      samples_seen++;
      if (m_tuser[0]) begin
        clipped_seen++;
      end
      if (sample_q.size() == 0) begin
        flag_mismatch("sample with none pending", 0, $signed(m_tdata));
      end else begin
        want = sample_q.pop_front();
        if (m_tdata !== want.value) begin
          flag_mismatch("sample", $signed(want.value), $signed(m_tdata));
        end
        if (m_tuser[0] !== want.clipped) begin
          flag_mismatch("clipped", want.clipped, m_tuser[0]);
        end
      end
    end
  end

  // cycles without any beat on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("timeout: no beat for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned k;
    int          ph;
    int          i;
    for (k = 0; k <= QTR; k++) begin
      quarter_sine[k] = quarter_entry(k);
    end
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: restart, then free running
    queue_beat(1'b1);
    repeat (3) queue_beat(1'b0);
    drain();

    // quarter-cycle steps with one harmonic at top gain: zero crossings,
    // positive and negative peaks that saturate, mirrored table end
    apply_setting(32'h4000_0000, 7'd1, 16'hFFFF);
    queue_beat(1'b1);
    repeat (4) queue_beat(1'b0);
    drain();

    // zero harmonics give silence
    apply_setting(32'h0100_0000, 7'd0, 16'd16384);
    queue_beat(1'b0);
    queue_beat(1'b1);
    drain();

    // harmonic count past the maximum, largest step wraps the phase
    apply_setting(32'hFFFF_FFFF, 7'd127, 16'hFFFF);
    queue_beat(1'b1);
    repeat (2) queue_beat(1'b0);
    drain();

    // zero gain with every harmonic
    apply_setting(32'h8000_0000, 7'd64, 16'd0);
    repeat (2) queue_beat(1'b0);
    drain();

    // frozen phase
    apply_setting(32'd0, 7'd64, 16'd16384);
    queue_beat(1'b0);
    queue_beat(1'b1);
    drain();

    // two harmonics at unity gain overshoot full scale
    apply_setting(32'h1555_5555, 7'd2, 16'd16384);
    queue_beat(1'b1);
    repeat (5) queue_beat(1'b0);
    drain();

    // random settings, each with a run of mostly free-running beats;
    // one phase runs without any gaps on either side
    for (ph = 0; ph < 11; ph++) begin
      random_setting();
      gaps_on = (ph != 5);
      for (i = 0; i < 48; i++) begin
        queue_beat($urandom_range(99) < 8);
      end
      drain();
    end
    gaps_on = 1'b1;

    if (sample_q.size() != 0) begin
      flag_mismatch("samples outstanding", 0, sample_q.size());
    end
    $display("covered %0d beats (%0d restarts), %0d samples checked, %0d clipped",
             beats_taken, restarts, samples_seen, clipped_seen);
    $display("%0d register writes over 17 settings, %0d mismatches",
             reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sawsyn_pkg.sv
src/sawsyn_sine_rom.sv
src/additive_sawtooth_synth_unit.sv
tb/sv/additive_sawtooth_synth_unit_test.sv
